/* sv/hsv_color_blob_centroid_top_defines.svh */
// assertion macros for the hsv colour blob centroid block
// depends on i_clk and i_rst_n being visible where the macros are used
`ifndef HSV_COLOR_BLOB_CENTROID_TOP_DEFINES_SVH
`define HSV_COLOR_BLOB_CENTROID_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HCB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define HCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/hcb_pkg.sv */
// shared types, constants and codes for the hsv colour blob centroid block
// no dependencies
`timescale 1ns / 1ps
package hcb_pkg;
    localparam int DIV_NUM_W = 30;
    localparam int DIV_DEN_W = 21;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
    localparam int DEF_MAX_ROWS = 1024;
    localparam int DEF_MAX_COLS = 1024;
    localparam logic [20:0] CNT_MAX = 21'h1FFFFF;
    localparam logic [30:0] SUM_MAX = 31'h3FFFFFFF;
    localparam logic [29:0] SAT_NUM = 30'd1044480; // 255 << 12
    localparam logic [29:0] HUE_NUM = 30'd737280;  // 180 << 12

    localparam logic [2:0] REG_HUE_LOW  = 3'd0;
    localparam logic [2:0] REG_HUE_HIGH = 3'd1;
    localparam logic [2:0] REG_SAT_LOW  = 3'd2;
    localparam logic [2:0] REG_SAT_HIGH = 3'd3;
    localparam logic [2:0] REG_VAL_LOW  = 3'd4;
    localparam logic [2:0] REG_VAL_HIGH = 3'd5;

    localparam logic [1:0] DS_SAT = 2'd0;
    localparam logic [1:0] DS_HUE = 2'd1;
    localparam logic [1:0] DS_ROW = 2'd2;
    localparam logic [1:0] DS_COL = 2'd3;

    typedef struct packed {
        logic [7:0] hue_low;
        logic [7:0] hue_high;
        logic [7:0] sat_low;
        logic [7:0] sat_high;
        logic [7:0] val_low;
        logic [7:0] val_high;
    } t_cfg;

    typedef struct packed {
        logic       load_px;
        logic       div_start;
        logic [1:0] div_sel;
        logic       mul;
        logic       sel;
        logic       acc;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic last;
    } t_dp_stat;
endpackage

/* sv/hsv_color_blob_centroid_top.sv */
// top level of the hsv colour blob centroid block
// depends on hcb_pkg, hcb_regs, hcb_ctrl, hcb_datapath and the defines header
//
//  channel  direction  handshake                 payload
//  pixel    in         i_in_valid / o_in_stall   i_red i_green i_blue i_pixel_row
//                                                i_pixel_col i_frame_end
//  result   out        o_out_valid / i_out_stall o_found o_centroid_row o_centroid_col
//  config   in         apb psel/penable/pwrite   paddr pwdata prdata pready
//
// a pixel passes from one accepting edge to the next through the idle state, two
// passes of the shared bit-serial divider (start, 30 quotient bits, done)
// for the reciprocals, then multiply, threshold and accumulate stages
// a frame-end pixel adds two more divider passes for the centroid and
// the result state before the input is free again
// one beat is in flight at a time; a waiting result holds the input stalled
// reset is synchronous and active low and restores the default thresholds
// the result beat holds steady while i_out_stall is high
`timescale 1ns / 1ps
`include "hsv_color_blob_centroid_top_defines.svh"
module hsv_color_blob_centroid_top
    import hcb_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [9:0]  i_pixel_row,
    input  logic [9:0]  i_pixel_col,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [9:0]  o_centroid_row,
    output logic [9:0]  o_centroid_col,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // threshold registers
    hcb_regs u_regs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg)
    );

    // sequencer
    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_stall(i_out_stall),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_cmd      (cmd)
    );

    // conversion, accumulation and divide
    hcb_datapath #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_pixel_row   (i_pixel_row),
        .i_pixel_col   (i_pixel_col),
        .i_frame_end   (i_frame_end),
        .o_stat        (stat),
        .o_found       (o_found),
        .o_centroid_row(o_centroid_row),
        .o_centroid_col(o_centroid_col)
    );

    // no pixel taken while a result waits
    `HCB_ASSERT_SAME(a_no_accept_on_result, !o_in_stall, !o_out_valid, "ready with result pending")
    // a taken pixel makes the block busy
    `HCB_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "not busy after beat")
    // a delivered result is not repeated
    `HCB_ASSERT_NEXT(a_result_once, o_out_valid && !i_out_stall, !o_out_valid, "result repeated")
    // empty frame reports a zero centroid
    `HCB_ASSERT_SAME(a_empty_zero, o_out_valid && !o_found,
        o_centroid_row == 10'd0 && o_centroid_col == 10'd0, "empty frame with centroid")
endmodule

/* sv/hcb_div.sv */
// restoring divider, one quotient bit per cycle
// depends on hcb_pkg
`timescale 1ns / 1ps
module hcb_div
    import hcb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quo,
    output logic [DIV_DEN_W-1:0] o_rem
);
    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic                 r_done;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 q_bit;

    assign rem_sh = {r_rem, r_quo[DIV_NUM_W-1]};
    assign q_bit  = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIV_NUM_W-2:0], q_bit};
                r_rem <= q_bit ? DIV_DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_DEN_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

/* sv/hcb_regs.sv */
// threshold register bank behind the apb port
// depends on hcb_pkg
`timescale 1ns / 1ps
module hcb_regs
    import hcb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    t_cfg       r_cfg;
    logic       wr;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_low  <= 8'd0;
            r_cfg.hue_high <= 8'd5;
            r_cfg.sat_low  <= 8'd100;
            r_cfg.sat_high <= 8'd255;
            r_cfg.val_low  <= 8'd20;
            r_cfg.val_high <= 8'd255;
        end else if (wr) begin
            unique case (idx)
                REG_HUE_LOW:  r_cfg.hue_low  <= pwdata[7:0];
                REG_HUE_HIGH: r_cfg.hue_high <= pwdata[7:0];
                REG_SAT_LOW:  r_cfg.sat_low  <= pwdata[7:0];
                REG_SAT_HIGH: r_cfg.sat_high <= pwdata[7:0];
                REG_VAL_LOW:  r_cfg.val_low  <= pwdata[7:0];
                REG_VAL_HIGH: r_cfg.val_high <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_HUE_LOW:  prdata = {24'd0, r_cfg.hue_low};
            REG_HUE_HIGH: prdata = {24'd0, r_cfg.hue_high};
            REG_SAT_LOW:  prdata = {24'd0, r_cfg.sat_low};
            REG_SAT_HIGH: prdata = {24'd0, r_cfg.sat_high};
            REG_VAL_LOW:  prdata = {24'd0, r_cfg.val_low};
            REG_VAL_HIGH: prdata = {24'd0, r_cfg.val_high};
            default:      prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

/* sv/hcb_datapath.sv */
// colour conversion, threshold test, accumulators and centroid divide
// depends on hcb_pkg and hcb_div
`timescale 1ns / 1ps
module hcb_datapath
    import hcb_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [9:0] i_pixel_row,
    input  logic [9:0] i_pixel_col,
    input  logic       i_frame_end,
    output t_dp_stat   o_stat,
    output logic       o_found,
    output logic [9:0] o_centroid_row,
    output logic [9:0] o_centroid_col
);
    logic [9:0]         r_row, r_col;
    logic               r_last;
    logic [7:0]         r_v, r_diff;
    logic signed [11:0] r_hnum;
    logic [19:0]        r_srecip;
    logic [16:0]        r_hrecip;
    logic [27:0]        r_sprod;
    logic signed [31:0] r_hprod;
    logic               r_sel;
    logic [20:0]        r_cnt;
    logic [29:0]        r_rsum, r_csum;
    logic [9:0]         r_crow;
    logic               r_found;
    logic [9:0]         r_orow, r_ocol;

    logic [7:0]           v, mn, diff;
    logic signed [11:0]   hnum;
    logic [DIV_NUM_W-1:0] d_num, d_quo;
    logic [DIV_DEN_W-1:0] d_den, d_rem;
    logic                 d_done;
    logic [DIV_NUM_W-1:0] q_rnd;
    logic [27:0]          s_t;
    logic signed [31:0]   h_t, h_fin;
    logic                 sel_now, fits;

    // max, min and hue numerator of the incoming pixel
    always_comb begin
        v  = i_red;
        mn = i_red;
        if (i_green > v) v = i_green;
        if (i_blue > v) v = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        diff = v - mn;
        if (v == i_red)
            hnum = $signed({4'd0, i_green}) - $signed({4'd0, i_blue});
        else if (v == i_green)
            hnum = $signed({4'd0, i_blue}) - $signed({4'd0, i_red})
                 + $signed({3'd0, diff, 1'b0});
        else
            hnum = $signed({4'd0, i_red}) - $signed({4'd0, i_green})
                 + $signed({2'd0, diff, 2'b0});
    end

    always_comb begin
        unique case (i_cmd.div_sel)
            DS_SAT: begin d_num = SAT_NUM; d_den = DIV_DEN_W'(r_v); end
            DS_HUE: begin d_num = HUE_NUM; d_den = DIV_DEN_W'(11'(r_diff) * 11'd6); end
            DS_ROW: begin d_num = r_rsum;  d_den = r_cnt; end
            default: begin d_num = r_csum; d_den = r_cnt; end
        endcase
    end

    hcb_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (d_num),
        .i_den  (d_den),
        .o_done (d_done),
        .o_quo  (d_quo),
        .o_rem  (d_rem)
    );

    // round to nearest, ties to even
    assign q_rnd = d_quo + DIV_NUM_W'(({d_rem, 1'b0} > {1'b0, d_den}) ||
                   (({d_rem, 1'b0} == {1'b0, d_den}) && d_quo[0]));

    assign s_t   = (r_sprod + 28'd2048) >> 12;
    assign h_t   = (r_hprod + 32'sd2048) >>> 12;
    assign h_fin = (h_t < 0) ? h_t + 32'sd180 : h_t;
    assign sel_now = h_fin >= $signed({24'd0, i_cfg.hue_low})
                  && h_fin <= $signed({24'd0, i_cfg.hue_high})
                  && s_t >= 28'(i_cfg.sat_low) && s_t <= 28'(i_cfg.sat_high)
                  && r_v >= i_cfg.val_low && r_v <= i_cfg.val_high
                  && 32'(r_row) < MAX_ROWS && 32'(r_col) < MAX_COLS;
    assign fits = r_cnt < CNT_MAX
               && (31'(r_rsum) + 31'(r_row)) <= SUM_MAX
               && (31'(r_csum) + 31'(r_col)) <= SUM_MAX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_rsum  <= '0;
            r_csum  <= '0;
            r_last  <= 1'b0;
            r_found <= 1'b0;
            r_orow  <= '0;
            r_ocol  <= '0;
        end else begin
            if (i_cmd.load_px) begin
                r_row  <= i_pixel_row;
                r_col  <= i_pixel_col;
                r_last <= i_frame_end;
                r_v    <= v;
                r_diff <= diff;
                r_hnum <= hnum;
            end
            if (d_done) begin
                unique case (i_cmd.div_sel)
                    DS_SAT: r_srecip <= (r_v == 8'd0) ? 20'd0 : q_rnd[19:0];
                    DS_HUE: r_hrecip <= (r_diff == 8'd0) ? 17'd0 : q_rnd[16:0];
                    DS_ROW: r_crow <= d_quo[9:0];
                    default: begin
                        r_found <= r_cnt != 21'd0;
                        r_orow  <= (r_cnt != 21'd0) ? r_crow : 10'd0;
                        r_ocol  <= (r_cnt != 21'd0) ? d_quo[9:0] : 10'd0;
                        r_cnt   <= '0;
                        r_rsum  <= '0;
                        r_csum  <= '0;
                    end
                endcase
            end
            if (i_cmd.mul) begin
                r_sprod <= 28'(r_diff * r_srecip);
                r_hprod <= 32'(r_hnum * $signed({1'b0, r_hrecip}));
            end
            if (i_cmd.sel) r_sel <= sel_now;
            if (i_cmd.acc && r_sel && fits) begin
                r_cnt  <= r_cnt + 21'd1;
                r_rsum <= r_rsum + 30'(r_row);
                r_csum <= r_csum + 30'(r_col);
            end
        end
    end

    assign o_stat.div_done = d_done;
    assign o_stat.last     = r_last;
    assign o_found         = r_found;
    assign o_centroid_row  = r_orow;
    assign o_centroid_col  = r_ocol;
endmodule

/* sv/hcb_ctrl.sv */
// sequencer for pixel conversion, accumulation and the frame result
// depends on hcb_pkg
`timescale 1ns / 1ps
module hcb_ctrl
    import hcb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIVS = 4'd1;
    localparam logic [3:0] ST_DIVH = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_SEL  = 4'd4;
    localparam logic [3:0] ST_ACC  = 4'd5;
    localparam logic [3:0] ST_DIVR = 4'd6;
    localparam logic [3:0] ST_DIVC = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_kick, n_kick;

    always_comb begin
        n_state = r_state;
        n_kick  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load_px = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DIVS;
                    n_kick  = 1'b1;
                end
            end
            ST_DIVS: begin
                o_cmd.div_sel = DS_SAT;
                if (i_stat.div_done) begin
                    n_state = ST_DIVH;
                    n_kick  = 1'b1;
                end
            end
            ST_DIVH: begin
                o_cmd.div_sel = DS_HUE;
                if (i_stat.div_done) n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SEL;
            end
            ST_SEL: begin
                o_cmd.sel = 1'b1;
                n_state   = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_stat.last) begin
                    n_state = ST_DIVR;
                    n_kick  = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIVR: begin
                o_cmd.div_sel = DS_ROW;
                if (i_stat.div_done) begin
                    n_state = ST_DIVC;
                    n_kick  = 1'b1;
                end
            end
            ST_DIVC: begin
                o_cmd.div_sel = DS_COL;
                if (i_stat.div_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.div_start = r_kick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kick  <= n_kick;
        end
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_state == ST_OUT;
endmodule
